// ===== design/assert_macros.svh =====
// Assertion macros shared by the decoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge of clk_i while rst_ni is high.
`define CRLD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never hold on a rising edge of clk_i outside reset.
`define CRLD_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== design/crld_pkg.sv =====
// Types and constants shared by the coefficient run-length decoder.
package crld_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned CoefW     = 16;
  localparam int unsigned PosOutW   = 6;
  localparam int unsigned CountW    = 7;
  localparam int unsigned LenW      = 6;
  localparam int unsigned MaxRepeat = 64;
  localparam int unsigned QueueDepth = 2;

  // Opcode bit positions.
  localparam int unsigned OpRepeatBit = 7;
  localparam int unsigned OpNarrowBit = 6;

  // Command handed from the parser to the expander: one complete value.
  typedef struct packed {
    logic signed [CoefW-1:0]  value;
    logic        [CountW-1:0] count;  // results to emit before clipping
    logic                     first;  // first value after an opcode
  } cmd_t;

endpackage

// ===== design/crld_byte_if.sv =====
// Byte channel: valid/ready handshake carrying one coded stream byte.
interface crld_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

// ===== design/crld_coef_if.sv =====
// Coefficient channel: valid/ready handshake carrying one decoded coefficient.
interface crld_coef_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] coefficient;
  logic        [5:0]  position;
  logic               block_end;
  logic               run_end;

  modport source (output valid, output coefficient, output position,
                  output block_end, output run_end, input ready);
  modport sink   (input valid, input coefficient, input position,
                  input block_end, input run_end, output ready);
endinterface

// ===== design/crld_queue.sv =====
// Short command queue between the byte parser and the coefficient expander.
module crld_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  crld_pkg::cmd_t push_cmd_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output crld_pkg::cmd_t pop_cmd_o
);
  import crld_pkg::*;
  `include "assert_macros.svh"

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  cmd_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign push_ready_o = (cnt_q != CntW'(QueueDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_cmd_o    = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  `CRLD_ASSERT(a_fill_in_range, cnt_q <= CntW'(QueueDepth), "queue fill beyond depth")

endmodule

// ===== design/crld_parser.sv =====
// Byte parser: decodes opcodes, assembles values and queues one command per value.
module crld_parser (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           byte_valid_i,
  output logic           byte_ready_o,
  input  logic [7:0]     byte_i,
  output logic           cmd_valid_o,
  input  logic           cmd_ready_i,
  output crld_pkg::cmd_t cmd_o
);
  import crld_pkg::*;

  localparam logic [1:0] PhOpcode = 2'd0;
  localparam logic [1:0] PhFirst  = 2'd1;
  localparam logic [1:0] PhHigh   = 2'd2;

  logic [1:0]        phase_q, phase_d;
  logic              is_repeat_q, is_repeat_d;
  logic              is_wide_q, is_wide_d;
  logic [CountW-1:0] remaining_q, remaining_d;
  logic [ByteW-1:0]  low_byte_q, low_byte_d;
  logic              first_q, first_d;
  logic              take;
  logic              deliver;
  logic [CoefW-1:0]  value;
  logic [LenW-1:0]   len;
  logic              op_repeat;

  // Each byte is finished in its own cycle; stall only on a full queue.
  assign byte_ready_o = cmd_ready_i;
  assign take         = byte_valid_i && byte_ready_o;
  assign len          = byte_i[LenW-1:0];
  assign op_repeat    = byte_i[OpRepeatBit];

  always_comb begin
    phase_d     = phase_q;
    is_repeat_d = is_repeat_q;
    is_wide_d   = is_wide_q;
    remaining_d = remaining_q;
    low_byte_d  = low_byte_q;
    first_d     = first_q;
    deliver     = 1'b0;
    value       = {{(CoefW-ByteW){byte_i[ByteW-1]}}, byte_i};
    if (take) begin
      case (phase_q)
        PhFirst: begin
          if (is_wide_q) begin
            low_byte_d = byte_i;
            phase_d    = PhHigh;
          end else begin
            deliver = 1'b1;
          end
        end
        PhHigh: begin
          value   = {byte_i, low_byte_q};
          deliver = 1'b1;
        end
        default: begin
          is_repeat_d = op_repeat;
          is_wide_d   = !byte_i[OpNarrowBit];
          first_d     = 1'b1;
          if (op_repeat && len == '0) begin
            remaining_d = CountW'(MaxRepeat);
          end else begin
            remaining_d = CountW'(len);
          end
          phase_d = (op_repeat || len != '0) ? PhFirst : PhOpcode;
        end
      endcase
      if (deliver) begin
        first_d = 1'b0;
        if (is_repeat_q) begin
          remaining_d = '0;
          phase_d     = PhOpcode;
        end else begin
          remaining_d = remaining_q - 1'b1;
          phase_d     = (remaining_q == CountW'(1)) ? PhOpcode : PhFirst;
        end
      end
    end
  end

  assign cmd_valid_o = deliver;
  assign cmd_o.value = value;
  assign cmd_o.count = is_repeat_q ? remaining_q : CountW'(1);
  assign cmd_o.first = first_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhOpcode;
      is_repeat_q <= 1'b0;
      is_wide_q   <= 1'b0;
      remaining_q <= '0;
      low_byte_q  <= '0;
      first_q     <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      is_repeat_q <= is_repeat_d;
      is_wide_q   <= is_wide_d;
      remaining_q <= remaining_d;
      low_byte_q  <= low_byte_d;
      first_q     <= first_d;
    end
  end

endmodule

// ===== design/crld_expander.sv =====
// Coefficient expander: turns queued commands into positioned coefficients.
module crld_expander #(
  parameter int unsigned BLOCK_SIZE = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  output logic                cmd_ready_o,
  input  crld_pkg::cmd_t      cmd_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [15:0]  coefficient_o,
  output logic [5:0]          position_o,
  output logic                block_end_o,
  output logic                run_end_o
);
  import crld_pkg::*;
  `include "assert_macros.svh"

  localparam int unsigned PosW = $clog2(BLOCK_SIZE + 1);

  logic [PosW-1:0]   pos_q, pos_d;
  logic [CountW-1:0] done_q, done_d;
  logic [PosW-1:0]   eff_pos;
  logic              advance;
  logic              room;
  logic              last;
  logic              emit;

  logic               out_valid_q, out_valid_d;
  logic signed [15:0] coef_q;
  logic [5:0]         posn_q;
  logic               block_end_q;
  logic               run_end_q;

  assign advance = !out_valid_q || out_ready_i;

  // A new run after a full block restarts at position zero.
  assign eff_pos = (cmd_i.first && pos_q >= PosW'(BLOCK_SIZE)) ? '0 : pos_q;
  assign room    = eff_pos < PosW'(BLOCK_SIZE);
  assign last    = (done_q + 1'b1 == cmd_i.count) || (eff_pos == PosW'(BLOCK_SIZE - 1));
  assign emit    = advance && cmd_valid_i && room;

  // Pop on the final result, or drop a value that finds the block full.
  assign cmd_ready_o = advance && (!room || last);

  always_comb begin
    pos_d       = pos_q;
    done_d      = done_q;
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = emit;
    end
    if (emit) begin
      pos_d  = eff_pos + 1'b1;
      done_d = last ? '0 : done_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      done_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      coef_q      <= cmd_i.value;
      posn_q      <= PosOutW'(eff_pos);
      block_end_q <= (eff_pos == PosW'(BLOCK_SIZE - 1));
      run_end_q   <= last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign coefficient_o = coef_q;
  assign position_o    = posn_q;
  assign block_end_o   = block_end_q;
  assign run_end_o     = run_end_q;

  `CRLD_ASSERT(a_pos_in_block, out_valid_q |-> PosW'(posn_q) < PosW'(BLOCK_SIZE), "bad position")
  `CRLD_ASSERT(a_block_end_closes_run, out_valid_q && block_end_q |-> run_end_q, "run end missing")

endmodule

// ===== design/coefficient_run_length_decoder.sv =====
// Top level of the coefficient run-length decoder.
// Takes one coded byte per transfer and delivers decoded coefficients with
// their block position. The byte parser finishes every byte in the cycle it
// is taken and writes one command per complete value into a two-entry queue;
// the expander reads that queue and emits one coefficient per cycle while the
// output is ready, so bytes keep flowing during a repeat run until the queue
// fills. Opcodes and low bytes of 16-bit values produce no output; a value of
// a run that arrives after the block is full is dropped and produces nothing.
// A coefficient goes from the queue into the expander's output register once
// its last byte is transferred, the queue holds nothing older and the output
// is free. There is no clearing pass after reset.
module coefficient_run_length_decoder #(
  parameter int unsigned BLOCK_SIZE = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  crld_byte_if.sink         byte_i,
  crld_coef_if.source       coef_o
);
  import crld_pkg::*;

  logic cmd_in_valid, cmd_in_ready;
  logic cmd_out_valid, cmd_out_ready;
  cmd_t cmd_in, cmd_out;

  crld_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (byte_i.valid),
    .byte_ready_o (byte_i.ready),
    .byte_i       (byte_i.in_byte),
    .cmd_valid_o  (cmd_in_valid),
    .cmd_ready_i  (cmd_in_ready),
    .cmd_o        (cmd_in)
  );

  crld_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (cmd_in_valid),
    .push_ready_o (cmd_in_ready),
    .push_cmd_i   (cmd_in),
    .pop_valid_o  (cmd_out_valid),
    .pop_ready_i  (cmd_out_ready),
    .pop_cmd_o    (cmd_out)
  );

  crld_expander #(
    .BLOCK_SIZE (BLOCK_SIZE)
  ) u_expander (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (cmd_out_valid),
    .cmd_ready_o   (cmd_out_ready),
    .cmd_i         (cmd_out),
    .out_valid_o   (coef_o.valid),
    .out_ready_i   (coef_o.ready),
    .coefficient_o (coef_o.coefficient),
    .position_o    (coef_o.position),
    .block_end_o   (coef_o.block_end),
    .run_end_o     (coef_o.run_end)
  );

endmodule
